// ===== sv/imm_pkg.sv =====
// Package: sizes and ALU operation codes of the interleaved modular multiplier.
`default_nettype none
package imm_pkg;

    localparam int NUM_BYTES  = 16;
    localparam int BYTE_W     = 8;
    localparam int ACC_BYTES  = 2 * NUM_BYTES;
    localparam int OPD_W      = BYTE_W * NUM_BYTES;
    localparam int ACC_W      = BYTE_W * ACC_BYTES;
    localparam int TOTAL_BITS = BYTE_W * NUM_BYTES;
    localparam int BIT_W      = $clog2(TOTAL_BITS);
    localparam int LOAD_W     = $clog2(NUM_BYTES + 1);
    localparam int BYTE_IDX_W = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
    localparam int OUT_W      = $clog2(ACC_BYTES);

    typedef enum logic {
        ALU_SHIFT_ADD,
        ALU_SUB
    } t_alu_op;

endpackage
`default_nettype wire

// ===== sv/imm_alu.sv =====
// Shared accumulator unit: shift-and-add or conditional subtract on one wide adder.
`default_nettype none
module imm_alu (
    input  wire logic [imm_pkg::ACC_W-1:0] i_acc,
    input  wire logic [imm_pkg::OPD_W-1:0] i_mcand,
    input  wire logic [imm_pkg::OPD_W-1:0] i_modulus,
    input  wire imm_pkg::t_alu_op          i_op,
    input  wire logic                      i_add_en,
    output logic      [imm_pkg::ACC_W-1:0] o_result
);
    import imm_pkg::*;

    logic [ACC_W-1:0] w_x;
    logic [ACC_W-1:0] w_y;
    logic             w_cin;
    logic [ACC_W:0]   w_sum;
    logic             w_keep;

    always_comb begin
        case (i_op)
            ALU_SHIFT_ADD: begin
                w_x   = {i_acc[ACC_W-2:0], 1'b0};
                w_y   = i_add_en ? {{(ACC_W-OPD_W){1'b0}}, i_mcand} : '0;
                w_cin = 1'b0;
            end
            ALU_SUB: begin
                w_x   = i_acc;
                w_y   = ~{{(ACC_W-OPD_W){1'b0}}, i_modulus};
                w_cin = 1'b1;
            end
            default: begin
                w_x   = i_acc;
                w_y   = '0;
                w_cin = 1'b0;
            end
        endcase
    end

    assign w_sum    = {1'b0, w_x} + {1'b0, w_y} + {{ACC_W{1'b0}}, w_cin};
    // borrow on subtract means acc < n: keep acc
    assign w_keep   = (i_op == ALU_SUB) && !w_sum[ACC_W];
    assign o_result = w_keep ? i_acc : w_sum[ACC_W-1:0];

endmodule
`default_nettype wire

// ===== sv/interleaved_modular_multiplier_top.sv =====
// Top level: byte-serial load, bit-serial a*b mod n, byte-serial result.
//
// Operands a, b and n arrive one byte position per input transfer, least
// significant first; the transfer with i_last_in set starts the work. The
// block then steps through each bit of a in the states S_ADD, S_SUB1 and
// S_SUB2 (shift-and-add, then two compare-and-subtract passes, all on one
// shared 256-bit adder), and then offers the 2*NUM_BYTES accumulator
// bytes, least significant first, one per output transfer, with o_last_out
// on the final byte. From the start until the last result byte is taken,
// o_in_ready is low. Bytes beyond NUM_BYTES before i_last_in are dropped.
`default_nettype none
module interleaved_modular_multiplier_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [imm_pkg::BYTE_W-1:0] i_a_byte,
    input  wire logic [imm_pkg::BYTE_W-1:0] i_b_byte,
    input  wire logic [imm_pkg::BYTE_W-1:0] i_modulus_byte,
    input  wire logic                       i_last_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [imm_pkg::BYTE_W-1:0] o_product_byte,
    output logic                            o_last_out
);
    import imm_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_ADD,
        S_SUB1,
        S_SUB2,
        S_OUT
    } t_state;

    t_state                              r_state,    n_state;
    logic   [LOAD_W-1:0]                 r_load_pos, n_load_pos;
    logic   [BIT_W-1:0]                  r_bit,      n_bit;
    logic   [OUT_W-1:0]                  r_out_cnt,  n_out_cnt;
    logic   [ACC_W-1:0]                  r_acc,      n_acc;
    logic   [NUM_BYTES-1:0][BYTE_W-1:0]  r_mul;
    logic   [NUM_BYTES-1:0][BYTE_W-1:0]  r_mcand;
    logic   [NUM_BYTES-1:0][BYTE_W-1:0]  r_mod;

    logic             w_in_xfer;
    logic             w_out_xfer;
    logic             w_store;
    logic [OPD_W-1:0] w_mul_flat;
    t_alu_op          w_op;
    logic [ACC_W-1:0] w_alu_result;

    assign o_in_ready     = (r_state == S_LOAD);
    assign o_out_valid    = (r_state == S_OUT);
    assign o_product_byte = r_acc[BYTE_W-1:0];
    assign o_last_out     = (r_out_cnt == OUT_W'(ACC_BYTES - 1));

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = o_out_valid && i_out_ready;
    assign w_store    = w_in_xfer && (r_load_pos < LOAD_W'(NUM_BYTES));
    assign w_mul_flat = r_mul;
    assign w_op       = (r_state == S_ADD) ? ALU_SHIFT_ADD : ALU_SUB;

    imm_alu u_alu (
        .i_acc     (r_acc),
        .i_mcand   (r_mcand),
        .i_modulus (r_mod),
        .i_op      (w_op),
        .i_add_en  (w_mul_flat[r_bit]),
        .o_result  (w_alu_result)
    );

    always_comb begin
        n_state    = r_state;
        n_load_pos = r_load_pos;
        n_bit      = r_bit;
        n_out_cnt  = r_out_cnt;
        n_acc      = r_acc;
        case (r_state)
            S_LOAD: begin
                if (w_store) begin
                    n_load_pos = r_load_pos + LOAD_W'(1);
                end
                if (w_in_xfer && i_last_in) begin
                    n_load_pos = '0;
                    n_bit      = BIT_W'(TOTAL_BITS - 1);
                    n_acc      = '0;
                    n_state    = S_ADD;
                end
            end
            S_ADD: begin
                n_acc   = w_alu_result;
                n_state = S_SUB1;
            end
            S_SUB1: begin
                n_acc   = w_alu_result;
                n_state = S_SUB2;
            end
            S_SUB2: begin
                n_acc = w_alu_result;
                if (r_bit == '0) begin
                    n_out_cnt = '0;
                    n_state   = S_OUT;
                end else begin
                    n_bit   = r_bit - BIT_W'(1);
                    n_state = S_ADD;
                end
            end
            S_OUT: begin
                if (w_out_xfer) begin
                    n_acc     = r_acc >> BYTE_W;
                    n_out_cnt = r_out_cnt + OUT_W'(1);
                    if (o_last_out) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_pos <= '0;
            r_bit      <= '0;
            r_out_cnt  <= '0;
        end else begin
            r_state    <= n_state;
            r_load_pos <= n_load_pos;
            r_bit      <= n_bit;
            r_out_cnt  <= n_out_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (w_store) begin
            r_mul[r_load_pos[BYTE_IDX_W-1:0]]   <= i_a_byte;
            r_mcand[r_load_pos[BYTE_IDX_W-1:0]] <= i_b_byte;
            r_mod[r_load_pos[BYTE_IDX_W-1:0]]   <= i_modulus_byte;
        end
    end

    a_sides_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output sides open together");

    a_start_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_last_in) |=> (!o_in_ready && !o_out_valid))
        else $error("start did not enter computation");

    a_last_reopens_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_last_out) |=> o_in_ready)
        else $error("input not reopened after final result byte");

    a_load_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_pos <= LOAD_W'(NUM_BYTES))
        else $error("load position beyond operand size");

    a_bit_steps_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUB2 && r_bit != '0) |=> (r_bit == $past(r_bit) - BIT_W'(1)))
        else $error("bit counter skipped");

endmodule
`default_nettype wire
